@@ hdl/line_position_pid_steer_assert.svh @@
// Assertion macros used by the steering controller's sequencer.
`ifndef LINE_POSITION_PID_STEER_ASSERT_SVH
`define LINE_POSITION_PID_STEER_ASSERT_SVH

// Antecedent implies consequent in the same cycle.
`define LPS_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the next cycle.
`define LPS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/lps_pkg.sv @@
// Shared types, constants and helper functions of the steering controller.
package lps_pkg;

  localparam int SENSOR_BITS_DEF = 12;
  localparam int NUM_SENSORS = 5;
  localparam int CFG_IDX_BITS = 3;
  localparam int CFG_DATA_BITS = 60;

  localparam logic [CFG_IDX_BITS-1:0] REG_MIN_THR  = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_MAX_THR  = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_GAIN_P   = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_GAIN_I   = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_GAIN_D   = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_BASE     = 3'd5;

  localparam logic [59:0] MIN_THR_RESET = 60'd98540299539046750;
  localparam logic [59:0] MAX_THR_RESET = 60'd197080599078093500;
  localparam logic [15:0] GAIN_P_RESET = 16'd1024;
  localparam logic [15:0] GAIN_I_RESET = 16'd0;
  localparam logic [15:0] GAIN_D_RESET = 16'd307;
  localparam logic [7:0]  BASE_RESET   = 8'd25;

  // Divider width: magnitude operands up to 64 bits.
  localparam int DIV_BITS = 64;

  // The integral step divides a product below 2^30 by 1000 as a multiply by
  // ceil(2^40/1000) followed by a 40-bit right shift, exact over that range.
  localparam logic [30:0] INTEG_RECIP = 31'd1099511628;
  localparam int INTEG_SHIFT = 40;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WEIGHT,
    ST_WEIGHT_WAIT,
    ST_POS,
    ST_POS_WAIT,
    ST_INTEG,
    ST_INTEG_WAIT,
    ST_DERIV,
    ST_DERIV_WAIT,
    ST_MUL_P,
    ST_MUL_I,
    ST_MUL_D,
    ST_FINISH,
    ST_OUT
  } lps_state_t;

  typedef enum logic [2:0] {
    DOP_NONE,
    DOP_WEIGHT,
    DOP_POS,
    DOP_DERIV
  } div_op_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load;
    logic [2:0] sensor;
    div_op_t    div_start;
    logic       weight_acc;
    logic       pos_take;
    logic       integ_prep;
    logic       integ_scale;
    logic       integ_take;
    logic       deriv_take;
    logic [1:0] mul_sel;
    logic       mul_go;
    logic       finish;
    logic       lost_finish;
  } lps_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_done;
    logic sensor_hit;
    logic den_zero;
  } lps_status_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) r = 32'sh7FFFFFFF;
    else if (v < -64'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

@@ hdl/lps_divider.sv @@
// Radix-2 restoring divider for unsigned operands, truncating quotient.
module lps_divider import lps_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [DIV_BITS-1:0] dividend,
  input  logic [DIV_BITS-1:0] divisor,
  output logic                done,
  output logic [DIV_BITS-1:0] quotient
);

  localparam int CNT_BITS = $clog2(DIV_BITS + 1);

  logic [DIV_BITS-1:0] rem;
  logic [DIV_BITS-1:0] rem_next;
  logic [DIV_BITS-1:0] quo;
  logic [DIV_BITS-1:0] dvs;
  logic [CNT_BITS-1:0] count;
  logic                busy;
  logic [DIV_BITS:0]   trial;

  always_comb begin
    trial = {rem, quo[DIV_BITS-1]} - {1'b0, dvs};
    rem_next = trial[DIV_BITS] ? {rem[DIV_BITS-2:0], quo[DIV_BITS-1]} : trial[DIV_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        count <= CNT_BITS'(DIV_BITS);
        rem <= '0;
        quo <= dividend;
        dvs <= divisor;
      end else if (busy) begin
        rem <= rem_next;
        quo <= {quo[DIV_BITS-2:0], ~trial[DIV_BITS]};
        count <= count - 1'b1;
        if (count == CNT_BITS'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = quo;

endmodule

@@ hdl/lps_datapath.sv @@
// Datapath: sensor windows, sums, divider, PID arithmetic and result registers.
module lps_datapath import lps_pkg::*; #(
  parameter int SENSOR_BITS = SENSOR_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  lps_cmd_t                     cmd,
  output lps_status_t                  status,
  input  logic [NUM_SENSORS*SENSOR_BITS-1:0] samples,
  input  logic [15:0]                  elapsed_ms,
  input  logic [59:0]                  min_thr,
  input  logic [59:0]                  max_thr,
  input  logic [15:0]                  gain_p,
  input  logic [15:0]                  gain_i,
  input  logic [15:0]                  gain_d,
  input  logic [7:0]                   base,
  output logic [15:0]                  left_speed,
  output logic [15:0]                  right_speed,
  output logic signed [23:0]           control_value,
  output logic signed [14:0]           line_position,
  output logic                         line_lost
);

  localparam int PACK_BITS = NUM_SENSORS * SENSOR_BITS;

  logic [PACK_BITS-1:0] smp;
  logic [15:0]          dt;
  logic [PACK_BITS-1:0] min_ext;
  logic [PACK_BITS-1:0] max_ext;

  // Threshold bits beyond bit 59 read as zero; the registers are 60 bits.
  always_comb begin
    min_ext = '0;
    max_ext = '0;
    for (int b = 0; b < PACK_BITS; b++) begin
      if (b < 60) begin
        min_ext[b] = min_thr[b];
        max_ext[b] = max_thr[b];
      end
    end
  end

  logic [SENSOR_BITS-1:0] s_cur;
  logic [SENSOR_BITS-1:0] lo_cur;
  logic [SENSOR_BITS-1:0] hi_cur;
  logic                   hit;
  logic [SENSOR_BITS:0]   span;

  always_comb begin
    s_cur = smp[cmd.sensor*SENSOR_BITS +: SENSOR_BITS];
    lo_cur = min_ext[cmd.sensor*SENSOR_BITS +: SENSOR_BITS];
    hi_cur = max_ext[cmd.sensor*SENSOR_BITS +: SENSOR_BITS];
    hit = (s_cur >= lo_cur) && (s_cur <= hi_cur);
    span = {1'b0, s_cur} - {1'b0, lo_cur} + 1'b1;
  end

  logic signed [23:0] num;
  logic [19:0]        den;
  logic signed [15:0] pos;
  logic signed [31:0] integ;
  logic signed [15:0] last_err;
  logic signed [31:0] deriv;
  logic signed [49:0] acc;
  logic signed [49:0] prod;
  logic               div_start;
  logic [DIV_BITS-1:0] dividend;
  logic [DIV_BITS-1:0] divisor;
  logic               div_done;
  logic [DIV_BITS-1:0] quotient;
  logic               neg;
  logic signed [DIV_BITS-1:0] sq;
  logic signed [16:0] err;
  logic signed [33:0] ediff;
  logic signed [63:0] dnum;
  logic signed [33:0] eprod;
  logic [29:0]        imag;
  logic               ineg;
  logic [60:0]        iscaled;
  logic signed [31:0] iq;

  assign err = -{pos[15], pos};
  assign ediff = 34'(err) - 34'(last_err);
  assign eprod = 34'(err) * 34'($signed({1'b0, dt}));
  assign iscaled = 61'(imag) * 61'(INTEG_RECIP);

  always_comb begin
    div_start = cmd.div_start != DOP_NONE;
    dividend = '0;
    divisor = 64'd1;
    dnum = '0;
    case (cmd.div_start)
      DOP_WEIGHT: begin
        dividend = 64'd65536;
        divisor = 64'(span);
      end
      DOP_POS: begin
        dividend = 64'(num[23] ? -num : num) << 12;
        divisor = 64'(den);
      end
      DOP_DERIV: begin
        dnum = 64'(ediff) * 64'sd1000;
        dividend = dnum[63] ? -dnum : dnum;
        divisor = 64'(dt);
      end
      default: begin
        dividend = '0;
      end
    endcase
  end

  lps_divider u_div (
    .clk(clk), .rst(rst), .start(div_start),
    .dividend(dividend), .divisor(divisor),
    .done(div_done), .quotient(quotient)
  );

  always_ff @(posedge clk) begin
    if (cmd.div_start == DOP_POS) neg <= num[23];
    else if (cmd.div_start == DOP_DERIV) neg <= ediff[33];
  end

  assign sq = neg ? -$signed(quotient) : $signed(quotient);

  // One Q8.8 gain product per cycle.
  always_comb begin
    case (cmd.mul_sel)
      2'd0: prod = 50'($signed({1'b0, gain_p})) * 50'(err);
      2'd1: prod = 50'($signed({1'b0, gain_i})) * 50'(integ);
      default: prod = 50'($signed({1'b0, gain_d})) * 50'(deriv);
    endcase
  end

  logic signed [49:0] nacc;
  logic signed [49:0] uq;
  logic signed [23:0] u;
  logic signed [25:0] lft;
  logic signed [25:0] rgt;

  always_comb begin
    nacc = -acc;
    uq = nacc[49] ? -((-nacc) >>> 12) : (nacc >>> 12);
    if (uq > 50'sd8388607) u = 24'sh7FFFFF;
    else if (uq < -50'sd8388608) u = 24'sh800000;
    else u = uq[23:0];
    lft = 26'({base, 8'd0}) + 26'(u);
    rgt = 26'({base, 8'd0}) - 26'(u);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      integ <= '0;
      last_err <= '0;
    end else begin
      if (cmd.integ_take) integ <= sat32(64'(integ) + 64'(iq));
      if (cmd.finish) last_err <= err[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      smp <= samples;
      dt <= (elapsed_ms == 16'd0) ? 16'd10 : elapsed_ms;
      num <= '0;
      den <= '0;
      acc <= '0;
    end
    if (cmd.weight_acc) begin
      den <= den + 20'(quotient);
      num <= num + 24'($signed({3'b0, cmd.sensor}) - 6'sd2) * 24'($signed({1'b0, quotient[16:0]}));
    end
    if (cmd.pos_take) pos <= sq[15:0];
    if (cmd.integ_prep) begin
      imag <= eprod[33] ? 30'(-eprod) : 30'(eprod);
      ineg <= eprod[33];
    end
    if (cmd.integ_scale) begin
      iq <= ineg ? -32'(iscaled[INTEG_SHIFT +: 21]) : 32'(iscaled[INTEG_SHIFT +: 21]);
    end
    if (cmd.deriv_take) deriv <= sq[31:0];
    if (cmd.mul_go) acc <= acc + prod;
    if (cmd.finish) begin
      line_lost <= 1'b0;
      control_value <= u;
      line_position <= pos[14:0];
      left_speed <= lft[25] ? 16'd0 : ((|lft[24:16]) ? 16'hFFFF : lft[15:0]);
      right_speed <= rgt[25] ? 16'd0 : ((|rgt[24:16]) ? 16'hFFFF : rgt[15:0]);
    end
    if (cmd.lost_finish) begin
      line_lost <= 1'b1;
      control_value <= '0;
      line_position <= '0;
      left_speed <= '0;
      right_speed <= '0;
    end
  end

  assign status = '{div_done: div_done, sensor_hit: hit, den_zero: den == 20'd0};

endmodule

@@ hdl/lps_control.sv @@
// Sequencer that steps the datapath through one control update.
module lps_control import lps_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  output lps_cmd_t    cmd,
  input  lps_status_t status
);

  lps_state_t state;
  lps_state_t state_next;
  logic [2:0] sensor;
  logic [2:0] sensor_next;

  always_comb begin
    state_next = state;
    sensor_next = sensor;
    case (state)
      ST_IDLE: if (in_valid) begin
        state_next = ST_WEIGHT;
        sensor_next = '0;
      end
      ST_WEIGHT: begin
        if (status.sensor_hit) state_next = ST_WEIGHT_WAIT;
        else if (sensor == 3'(NUM_SENSORS - 1)) state_next = ST_POS;
        else sensor_next = sensor + 1'b1;
      end
      ST_WEIGHT_WAIT: if (status.div_done) begin
        if (sensor == 3'(NUM_SENSORS - 1)) state_next = ST_POS;
        else begin
          state_next = ST_WEIGHT;
          sensor_next = sensor + 1'b1;
        end
      end
      ST_POS: state_next = status.den_zero ? ST_OUT : ST_POS_WAIT;
      ST_POS_WAIT: if (status.div_done) state_next = ST_INTEG;
      ST_INTEG: state_next = ST_INTEG_WAIT;
      ST_INTEG_WAIT: state_next = ST_DERIV;
      ST_DERIV: state_next = ST_DERIV_WAIT;
      ST_DERIV_WAIT: if (status.div_done) state_next = ST_MUL_P;
      ST_MUL_P: state_next = ST_MUL_I;
      ST_MUL_I: state_next = ST_MUL_D;
      ST_MUL_D: state_next = ST_FINISH;
      ST_FINISH: state_next = ST_OUT;
      ST_OUT: if (out_ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.div_start = DOP_NONE;
    cmd.sensor = sensor;
    in_ready = 1'b0;
    out_valid = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_WEIGHT: if (status.sensor_hit) cmd.div_start = DOP_WEIGHT;
      ST_WEIGHT_WAIT: cmd.weight_acc = status.div_done;
      ST_POS: begin
        if (status.den_zero) cmd.lost_finish = 1'b1;
        else cmd.div_start = DOP_POS;
      end
      ST_POS_WAIT: cmd.pos_take = status.div_done;
      ST_INTEG: cmd.integ_prep = 1'b1;
      ST_INTEG_WAIT: cmd.integ_scale = 1'b1;
      ST_DERIV: begin
        cmd.div_start = DOP_DERIV;
        cmd.integ_take = 1'b1;
      end
      ST_DERIV_WAIT: cmd.deriv_take = status.div_done;
      ST_MUL_P: begin
        cmd.mul_sel = 2'd0;
        cmd.mul_go = 1'b1;
      end
      ST_MUL_I: begin
        cmd.mul_sel = 2'd1;
        cmd.mul_go = 1'b1;
      end
      ST_MUL_D: begin
        cmd.mul_sel = 2'd2;
        cmd.mul_go = 1'b1;
      end
      ST_FINISH: cmd.finish = 1'b1;
      ST_OUT: out_valid = 1'b1;
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      sensor <= '0;
    end else begin
      state <= state_next;
      sensor <= sensor_next;
    end
  end

`include "line_position_pid_steer_assert.svh"

  `LPS_ASSERT_IMP(a_ready_only_idle, clk, rst, in_ready, !out_valid, "input and output both open")
  `LPS_ASSERT_NEXT(a_load_leaves_idle, clk, rst, cmd.load, state == ST_WEIGHT, "load did not start")
  `LPS_ASSERT_IMP(a_sensor_range, clk, rst, state == ST_WEIGHT, sensor < 3'(NUM_SENSORS), "sensor index out of range")

endmodule

@@ hdl/line_position_pid_steer.sv @@
// Top level of the line-following PID steering controller.
// Each update runs one weight division for each sensor whose sample lies in its window,
// then the position and derivative divisions; with the line lost it ends after the
// weights. A single 64-step radix-2 divider is shared by the weights, the position and
// the derivative; the integral divides by 1000 with a reciprocal multiply.
// Results hold until taken, and no new input beat is taken before the result beat.
// Configuration writes are taken at any time and should be made only while the
// block is idle.
module line_position_pid_steer import lps_pkg::*; #(
  parameter int SENSOR_BITS = SENSOR_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [SENSOR_BITS-1:0]  sample_0,
  input  logic [SENSOR_BITS-1:0]  sample_1,
  input  logic [SENSOR_BITS-1:0]  sample_2,
  input  logic [SENSOR_BITS-1:0]  sample_3,
  input  logic [SENSOR_BITS-1:0]  sample_4,
  input  logic [15:0]             elapsed_ms,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [15:0]             left_speed,
  output logic [15:0]             right_speed,
  output logic signed [23:0]      control_value,
  output logic signed [14:0]      line_position,
  output logic                    line_lost
);

  logic [59:0] min_thr;
  logic [59:0] max_thr;
  logic [15:0] gain_p;
  logic [15:0] gain_i;
  logic [15:0] gain_d;
  logic [7:0]  base;
  lps_cmd_t    cmd;
  lps_status_t status;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_thr <= MIN_THR_RESET;
      max_thr <= MAX_THR_RESET;
      gain_p <= GAIN_P_RESET;
      gain_i <= GAIN_I_RESET;
      gain_d <= GAIN_D_RESET;
      base <= BASE_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MIN_THR: min_thr <= cfg_data;
        REG_MAX_THR: max_thr <= cfg_data;
        REG_GAIN_P: gain_p <= cfg_data[15:0];
        REG_GAIN_I: gain_i <= cfg_data[15:0];
        REG_GAIN_D: gain_d <= cfg_data[15:0];
        REG_BASE: base <= cfg_data[7:0];
        default: base <= base;
      endcase
    end
  end

  lps_control u_ctl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .cmd(cmd), .status(status)
  );

  lps_datapath #(.SENSOR_BITS(SENSOR_BITS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .status(status),
    .samples({sample_4, sample_3, sample_2, sample_1, sample_0}),
    .elapsed_ms(elapsed_ms), .min_thr(min_thr), .max_thr(max_thr),
    .gain_p(gain_p), .gain_i(gain_i), .gain_d(gain_d), .base(base),
    .left_speed(left_speed), .right_speed(right_speed),
    .control_value(control_value), .line_position(line_position),
    .line_lost(line_lost)
  );

endmodule
